FILE: rtl/cflw_pkg.sv
package cflw_pkg;

  // Flash geometry
  localparam int unsigned PageShift   = 8;    // 256-byte pages
  localparam int unsigned SectorShift = 12;   // 4096-byte sectors
  localparam int unsigned AddrW       = 32;
  localparam int unsigned CountW      = 17;   // page counts up to 65536
  localparam int unsigned PageW       = 16;   // page index
  localparam logic [CountW-1:0] MaxPages = 17'd65536;

  // Configuration register indexes
  localparam logic [1:0] RegBaseAddr   = 2'd0;
  localparam logic [1:0] RegTotalPages = 2'd1;
  localparam logic [1:0] RegKeepPages  = 2'd2;

  // Operations
  localparam logic OpNewPage = 1'b0;
  localparam logic OpSignal  = 1'b1;

  // Status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StNoData    = 3'd1;
  localparam logic [2:0] StSaturated = 3'd2;
  localparam logic [2:0] StOutOfBnd  = 3'd3;
  localparam logic [2:0] StAgain     = 3'd4;

  // Stop tracking modes
  localparam logic [1:0] ModeUnset   = 2'd0;
  localparam logic [1:0] ModePending = 2'd1;
  localparam logic [1:0] ModeFixed   = 2'd2;

  // One result word
  typedef struct packed {
    logic [AddrW-1:0] erase_address;
    logic             erase_request;
    logic [AddrW-1:0] write_address;
    logic             write_request;
    logic [2:0]       status;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

FILE: rtl/circular_flash_log_writer.sv
// Circular flash log writer: write pointer control for a flash partition
// used as a ring of 256-byte pages in 4096-byte sectors.
// Input stream (s_axis): one word per item; tuser is the operation (new page
// or end-of-circle signal), tdata bit 0 says whether page data is present.
// Output stream (m_axis): one result word per input word carrying status, the
// page write command with its byte address and, when the pointer moves onto
// the start of a sector, an erase command for that sector.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 base address, 1 total pages, 2 keep pages); write only while idle.
// The result is in the output register in the cycle after the input word is
// accepted. Throughput: one word per cycle while results are taken; the pointer
// update is a single compare, increment and wrap done in the accept cycle.
// Stall: s_axis_tready drops only while a result sits in the output register
// and the receiver holds m_axis_tready low; the result stays stable meanwhile.
// Reset: pointer at page 0, no end-of-circle signal seen, base address 0,
// total pages 65536, keep pages 0, output empty.
module circular_flash_log_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] page_present, [7:1] zero
  input  logic        s_axis_tuser,   // [0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [3] write_request, [35:4] write_address,
  // [36] erase_request, [68:37] erase_address, [71:69] zero
  output logic [cflw_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned CountW = cflw_pkg::CountW;
  localparam int unsigned PageW  = cflw_pkg::PageW;
  localparam int unsigned AddrW  = cflw_pkg::AddrW;

  // Configuration registers
  logic [AddrW-1:0]  base_q;
  logic [CountW-1:0] total_q;
  logic [CountW-1:0] keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      total_q <= cflw_pkg::MaxPages;
      keep_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cflw_pkg::RegBaseAddr:   base_q  <= cfg_data_i;
        cflw_pkg::RegTotalPages: total_q <= cfg_data_i[CountW-1:0];
        cflw_pkg::RegKeepPages:  keep_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Pointer state
  logic [PageW-1:0] write_page_q, write_page_d;
  logic [1:0]       stop_mode_q, stop_mode_d;
  logic [PageW-1:0] stop_page_q, stop_page_d;

  // Output register
  logic              out_valid_q;
  cflw_pkg::result_t out_q, res_d;

  logic in_fire;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Per-item decode and pointer update
  logic [CountW-1:0] n_pages, keep_eff, wp_ext, stop_calc, next_ext;
  logic [PageW-1:0]  next_page;
  logic [1:0]        mode_eff;
  logic [PageW-1:0]  stop_eff;
  logic [AddrW-1:0]  cur_addr, next_addr;
  logic              op, present;

  always_comb begin
    op      = s_axis_tuser;
    present = s_axis_tdata[0];

    n_pages  = (total_q > cflw_pkg::MaxPages) ? cflw_pkg::MaxPages : total_q;
    keep_eff = (keep_q > n_pages) ? n_pages : keep_q;
    wp_ext   = {1'b0, write_page_q};

    // stop index keep pages behind the pointer, wrapped into the ring
    if (wp_ext >= keep_eff) begin
      stop_calc = wp_ext - keep_eff;
    end else begin
      stop_calc = wp_ext + n_pages - keep_eff;
    end

    // advance with wrap
    next_ext  = wp_ext + CountW'(1);
    next_page = (next_ext >= n_pages) ? '0 : next_ext[PageW-1:0];

    cur_addr  = base_q + {{(AddrW-PageW-cflw_pkg::PageShift){1'b0}}, write_page_q,
                          {cflw_pkg::PageShift{1'b0}}};
    next_addr = base_q + {{(AddrW-PageW-cflw_pkg::PageShift){1'b0}}, next_page,
                          {cflw_pkg::PageShift{1'b0}}};

    write_page_d = write_page_q;
    stop_mode_d  = stop_mode_q;
    stop_page_d  = stop_page_q;
    mode_eff     = stop_mode_q;
    stop_eff     = stop_page_q;
    res_d        = '0;
    res_d.status = cflw_pkg::StOk;

    if (op == cflw_pkg::OpSignal) begin
      if (stop_mode_q != cflw_pkg::ModeUnset) begin
        res_d.status = cflw_pkg::StAgain;
      end else begin
        stop_mode_d = cflw_pkg::ModePending;
      end
    end else if (!present) begin
      res_d.status = cflw_pkg::StNoData;
    end else begin
      // first page with data after the signal fixes the stop index
      if (stop_mode_q == cflw_pkg::ModePending) begin
        mode_eff    = cflw_pkg::ModeFixed;
        stop_eff    = stop_calc[PageW-1:0];
        stop_mode_d = cflw_pkg::ModeFixed;
        stop_page_d = stop_calc[PageW-1:0];
      end
      if (mode_eff == cflw_pkg::ModeFixed && write_page_q == stop_eff) begin
        res_d.status = cflw_pkg::StSaturated;
      end else if (wp_ext >= n_pages) begin
        res_d.status = cflw_pkg::StOutOfBnd;
      end else begin
        res_d.write_request = 1'b1;
        res_d.write_address = cur_addr;
        write_page_d        = next_page;
        // erase when the new pointer opens a sector
        if (next_addr[cflw_pkg::SectorShift-1:0] == '0) begin
          res_d.erase_request = 1'b1;
          res_d.erase_address = next_addr;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_page_q <= '0;
      stop_mode_q  <= cflw_pkg::ModeUnset;
      stop_page_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        write_page_q <= write_page_d;
        stop_mode_q  <= stop_mode_d;
        stop_page_q  <= stop_page_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(cflw_pkg::OutDataW-cflw_pkg::ResultW){1'b0}}, out_q};

`ifndef NO_ASSERTIONS
  // an erase always accompanies a page write
  a_erase_with_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.erase_request |-> out_q.write_request)
    else $error("erase without page write");

  // the write address is zero when no write is requested
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.write_request |-> out_q.write_address == '0)
    else $error("write address set without request");

  // a saturated discard only happens with a fixed stop index
  a_sat_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == cflw_pkg::StSaturated
    |-> stop_mode_q == cflw_pkg::ModeFixed)
    else $error("saturated without fixed stop");

  // a signal never moves the pointer
  a_signal_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser == cflw_pkg::OpSignal |=> $stable(write_page_q))
    else $error("pointer moved on signal");

  // the pointer does not move unless a write is commanded
  a_move_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !res_d.write_request |=> $stable(write_page_q))
    else $error("pointer moved without write");
`endif

endmodule

FILE: dv/flash_cmd_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both streams of the log writer, keeps its own
// copy of the ring pointer and stop tracking, and checks every result word.
module flash_cmd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [7:0]                    in_data_i,     // [0] page_present
  input  logic                          in_user_i,     // [0] operation
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [cflw_pkg::OutDataW-1:0] out_data_i,    // result_t in the low bits
  output int unsigned                   outstanding_o,
  output logic [cflw_pkg::PageW-1:0]    next_page_o,
  output int unsigned                   mismatch_count_o
);

  localparam int unsigned AddrW  = cflw_pkg::AddrW;
  localparam int unsigned CountW = cflw_pkg::CountW;
  localparam int unsigned PageW  = cflw_pkg::PageW;

  // register copies
  logic [AddrW-1:0]  base_address;
  logic [CountW-1:0] total_pages;
  logic [CountW-1:0] keep_pages;

  // ring pointer and stop tracking
  logic [PageW-1:0]  write_page;
  logic [1:0]        stop_mode;
  logic [PageW-1:0]  stop_page;

  cflw_pkg::result_t expected_cmds[$];
  int unsigned       outstanding;
  int unsigned       mismatch_count;

  assign outstanding_o    = outstanding;
  assign next_page_o      = write_page;
  assign mismatch_count_o = mismatch_count;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [AddrW-1:0] page_byte_addr(input logic [PageW-1:0] pg);
    return base_address + ({16'd0, pg} << cflw_pkg::PageShift);
  endfunction

  // Flash commands caused by one word; updates pointer and stop state.
  function automatic cflw_pkg::result_t next_flash_cmd(input logic op, input logic present);
    cflw_pkg::result_t cmd;
    logic [CountW-1:0] ring;
    logic [CountW-1:0] keep;
    logic [CountW-1:0] wrap_sum;
    logic [AddrW-1:0]  next_addr;
    cmd = '0;
    cmd.status = cflw_pkg::StOk;
    ring = (total_pages > cflw_pkg::MaxPages) ? cflw_pkg::MaxPages : total_pages;
    if (op == cflw_pkg::OpSignal) begin
      if (stop_mode != cflw_pkg::ModeUnset) cmd.status = cflw_pkg::StAgain;
      else stop_mode = cflw_pkg::ModePending;
    end else if (!present) begin
      cmd.status = cflw_pkg::StNoData;
    end else begin
      // first stored page after the signal fixes the stop index
      if (stop_mode == cflw_pkg::ModePending) begin
        keep = (keep_pages > ring) ? ring : keep_pages;
        if ({1'b0, write_page} >= keep) begin
          stop_page = write_page - keep[PageW-1:0];
        end else begin
          wrap_sum  = {1'b0, write_page} + ring - keep;
          stop_page = wrap_sum[PageW-1:0];
        end
        stop_mode = cflw_pkg::ModeFixed;
      end
      if (stop_mode == cflw_pkg::ModeFixed && write_page == stop_page) begin
        cmd.status = cflw_pkg::StSaturated;
      end else if ({1'b0, write_page} >= ring) begin
        cmd.status = cflw_pkg::StOutOfBnd;
      end else begin
        cmd.write_request = 1'b1;
        cmd.write_address = page_byte_addr(write_page);
        if ({1'b0, write_page} + 1 >= ring) write_page = '0;
        else write_page = write_page + 1'b1;
        // pointer landed on a sector start: erase it ahead of use
        next_addr = page_byte_addr(write_page);
        if (next_addr[cflw_pkg::SectorShift-1:0] == '0) begin
          cmd.erase_request = 1'b1;
          cmd.erase_address = next_addr;
        end
      end
    end
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cflw_pkg::result_t got;
    cflw_pkg::result_t want;
    if (!rst_ni) begin
      base_address = '0;
      total_pages  = cflw_pkg::MaxPages;
      keep_pages   = '0;
      write_page   = '0;
      stop_mode    = cflw_pkg::ModeUnset;
      stop_page    = '0;
      expected_cmds.delete();
      outstanding  = 0;
    end else begin
      // compare a delivered result word with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[cflw_pkg::ResultW-1:0];
        if (expected_cmds.size() == 0) begin
          flag_mismatch("unexpected result, status", got.status, '0);
        end else begin
          want = expected_cmds.pop_front();
          if (got.status != want.status)
            flag_mismatch("status", got.status, want.status);
          if (got.write_request != want.write_request)
            flag_mismatch("write_request", got.write_request, want.write_request);
          if (got.write_address != want.write_address)
            flag_mismatch("write_address", got.write_address, want.write_address);
          if (got.erase_request != want.erase_request)
            flag_mismatch("erase_request", got.erase_request, want.erase_request);
          if (got.erase_address != want.erase_address)
            flag_mismatch("erase_address", got.erase_address, want.erase_address);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_cmds.push_back(next_flash_cmd(in_user_i, in_data_i[0]));
      // register writes take effect after this edge
      if (cfg_we_i) begin
        case (cfg_index_i)
          cflw_pkg::RegBaseAddr:   base_address = cfg_data_i;
          cflw_pkg::RegTotalPages: total_pages  = cfg_data_i[CountW-1:0];
          cflw_pkg::RegKeepPages:  keep_pages   = cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      outstanding = expected_cmds.size();
    end
  end

endmodule

FILE: dv/circular_flash_log_writer_test.sv
`timescale 1ns / 1ps

// Drives page and end-of-circle words through the log writer under several
// ring settings and idling patterns, then triggers the freeze once at the end
// since a fixed stop index holds until reset.
module circular_flash_log_writer_test;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned CountW     = cflw_pkg::CountW;
  localparam int unsigned PageW      = cflw_pkg::PageW;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i;
  logic [1:0]                    cfg_index_i;
  logic [31:0]                   cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [cflw_pkg::OutDataW-1:0] m_axis_tdata;

  int unsigned         outstanding;
  int unsigned         mismatches;
  logic [PageW-1:0]    ptr;
  int unsigned         gap_pct;
  int unsigned         stall_pct;
  int unsigned         cycles;

  circular_flash_log_writer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  flash_cmd_checker cmd_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_user_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .outstanding_o    (outstanding),
    .next_page_o      (ptr),
    .mismatch_count_o (mismatches)
  );

  always #5 clk_i = ~clk_i;

  // receiver back-pressure
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic send_word(input logic op, input logic present);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, present};
    @(posedge clk_i iff s_axis_tready);
  endtask

  // stop sending and wait for every result word
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // a ring a little larger than the current pointer, so pages wrap soon
  function automatic logic [CountW-1:0] ring_above(input logic [PageW-1:0] pg);
    int unsigned sectors;
    sectors = (pg >> 4) + 1 + $urandom_range(0, 15);
    return CountW'(sectors << 4);
  endfunction

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("circular_flash_log_writer_test NOT OK");
    $finish;
  end

  initial begin
    int unsigned       ph;
    int unsigned       i;
    int unsigned       lim;
    int unsigned       gap;
    logic [CountW-1:0] ring;
    logic [31:0]       base;
    cycles        = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = cflw_pkg::RegBaseAddr;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = cflw_pkg::OpNewPage;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: fill the first sector, erase comes with the 16th write
    send_word(cflw_pkg::OpNewPage, 1'b1);
    send_word(cflw_pkg::OpNewPage, 1'b0);
    for (i = 0; i < 16; i++) send_word(cflw_pkg::OpNewPage, 1'b1);
    send_word(cflw_pkg::OpNewPage, 1'b0);
    settle();

    // ring shrunk below the pointer: out of bounds
    write_reg(cflw_pkg::RegTotalPages, 32'd16);
    write_reg(cflw_pkg::RegKeepPages, 32'h0001_FFFF);
    send_word(cflw_pkg::OpNewPage, 1'b1);
    send_word(cflw_pkg::OpNewPage, 1'b0);
    send_word(cflw_pkg::OpNewPage, 1'b1);
    settle();

    // empty ring
    write_reg(cflw_pkg::RegTotalPages, 32'd0);
    send_word(cflw_pkg::OpNewPage, 1'b1);
    settle();

    // top of the address space, page count above the cap
    write_reg(cflw_pkg::RegBaseAddr, 32'hFFFF_F000);
    write_reg(cflw_pkg::RegTotalPages, 32'h0001_FFFF);
    send_word(cflw_pkg::OpNewPage, 1'b1);
    send_word(cflw_pkg::OpNewPage, 1'b1);
    settle();

    // random phases before the trigger
    for (ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 64; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      case (ph)
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF;
        2:       base = 32'hFFFF_F000;
        default: base = ($urandom_range(0, 3) == 0) ? $urandom
                        : {20'($urandom_range(0, 32'hFFFFF)), 12'h000};
      endcase
      case (ph)
        4:       ring = cflw_pkg::MaxPages;
        5:       ring = 17'd16;
        7:       ring = CountW'($urandom_range(16, 131071));
        default: ring = ring_above(ptr);
      endcase
      write_reg(cflw_pkg::RegBaseAddr, base);
      write_reg(cflw_pkg::RegTotalPages, {15'd0, ring});
      case (ph)
        0:       write_reg(cflw_pkg::RegKeepPages, 32'd0);
        1:       write_reg(cflw_pkg::RegKeepPages, 32'd65536);
        2:       write_reg(cflw_pkg::RegKeepPages, 32'h0001_FFFF);
        default: write_reg(cflw_pkg::RegKeepPages, $urandom_range(0, 131071));
      endcase
      for (i = 0; i < 100; i++) begin
        send_word(cflw_pkg::OpNewPage, $urandom_range(0, 99) < 85);
        if (ph == 2 && i == 50) settle();
      end
      settle();
    end

    // trigger: freeze after a random number of further pages
    gap_pct   = 30;
    stall_pct = 30;
    ring = ring_above(ptr);
    lim  = (ring > 80) ? 80 : ring - 1;
    gap  = $urandom_range(0, lim);
    write_reg(cflw_pkg::RegTotalPages, {15'd0, ring});
    write_reg(cflw_pkg::RegKeepPages, (gap == 0) ? ring + 5 : ring - gap);
    send_word(cflw_pkg::OpSignal, 1'b0);
    send_word(cflw_pkg::OpSignal, 1'b1);
    send_word(cflw_pkg::OpNewPage, 1'b0);
    for (i = 0; i < 130; i++) begin
      if (i == 65) begin gap_pct = 0; stall_pct = 0; end
      send_word(($urandom_range(0, 9) == 0) ? cflw_pkg::OpSignal : cflw_pkg::OpNewPage,
                $urandom_range(0, 99) < 85);
    end
    settle();

    if (mismatches == 0) begin
      $display("circular_flash_log_writer_test OK");
    end else begin
      $display("circular_flash_log_writer_test NOT OK");
    end
    $finish;
  end

endmodule
